/* src/ebx_pkg.sv */
// ----------------------------------------------------------------------------
// ebx_pkg: shared types and constants of the instruction executor
// Opcode fields, controller states, command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none
package ebx_pkg;
   localparam int unsigned NumRegs = 16;
   localparam int unsigned MaxTextBytes = 65536;

   localparam logic [2:0] CLASS_ALU32 = 3'h4;
   localparam logic [2:0] CLASS_JMP   = 3'h5;
   localparam logic [2:0] CLASS_ALU64 = 3'h7;

   localparam logic [3:0] OP_ADD  = 4'h0;
   localparam logic [3:0] OP_SUB  = 4'h1;
   localparam logic [3:0] OP_MUL  = 4'h2;
   localparam logic [3:0] OP_DIV  = 4'h3;
   localparam logic [3:0] OP_OR   = 4'h4;
   localparam logic [3:0] OP_AND  = 4'h5;
   localparam logic [3:0] OP_LSH  = 4'h6;
   localparam logic [3:0] OP_RSH  = 4'h7;
   localparam logic [3:0] OP_NEG  = 4'h8;
   localparam logic [3:0] OP_MOD  = 4'h9;
   localparam logic [3:0] OP_XOR  = 4'ha;
   localparam logic [3:0] OP_MOV  = 4'hb;
   localparam logic [3:0] OP_ARSH = 4'hc;
   localparam logic [3:0] OP_END  = 4'hd;

   localparam logic [3:0] BR_JA  = 4'h0;
   localparam logic [3:0] BR_JEQ = 4'h1;
   localparam logic [3:0] BR_JGT = 4'h2;
   localparam logic [3:0] BR_JGE = 4'h3;
   localparam logic [3:0] BR_JSET = 4'h4;
   localparam logic [3:0] BR_JNE = 4'h5;
   localparam logic [3:0] BR_JLT = 4'ha;
   localparam logic [3:0] BR_JLE = 4'hb;

   localparam logic CSR_TEXT_SIZE  = 1'b0;
   localparam logic CSR_CONTINUOUS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_EXEC, ST_MUL, ST_DIV, ST_COMMIT, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;      // capture input beat
      logic exec;      // evaluate instruction
      logic mul_step;  // second multiplier stage
      logic div_start;
      logic commit;    // update state
      logic out_load;  // result register load
   } cmd_type;

   typedef struct packed {
      logic is_clear;
      logic needs_mul;
      logic needs_div;
      logic div_done;
   } sts_type;
endpackage
`default_nettype wire

/* src/ebpf_instruction_executor.sv */
// ----------------------------------------------------------------------------
// ebpf_instruction_executor: eBPF-style ALU and branch interpreter core
// Executes one instruction per request beat, one result beat per request.
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// req       in   req_valid/req_stall   action, instr_word
// rsp       out  rsp_valid/rsp_stall   status, next_ip, count, register
// csr       in   csr_valid/csr_ready   csr_index, csr_wdata
//
// The result follows the request beat through the read, execute, multiply,
// commit and out states; a clear skips the multiply state, and divide/modulo
// adds the divide state (one quotient bit a cycle in the divider).
// The next request beat is taken the cycle after the result register loads.
// The result register loads only once the previous result has gone; until
// then the core waits and new beats are stalled.
// Synchronous reset clears all architectural state at once.
// ----------------------------------------------------------------------------
`default_nettype none
module ebpf_instruction_executor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [63:0] req_instr_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_running,
   output logic             rsp_halted,
   output logic             rsp_div_zero,
   output logic             rsp_illegal_op,
   output logic [31:0]      rsp_next_ip,
   output logic [63:0]      rsp_cycle_count,
   output logic             rsp_reg_written,
   output logic [3:0]       rsp_reg_index,
   output logic [63:0]      rsp_reg_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [16:0] csr_wdata
);
   import ebx_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ebx_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd),
      .csr_ready (csr_ready)
   );

   ebx_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .in_action     (req_action),
      .in_word       (req_instr_word),
      .csr_wr        (csr_valid && csr_ready),
      .csr_idx       (csr_index),
      .csr_val       (csr_wdata),
      .o_running     (rsp_running),
      .o_halted      (rsp_halted),
      .o_div_zero    (rsp_div_zero),
      .o_illegal_op  (rsp_illegal_op),
      .o_next_ip     (rsp_next_ip),
      .o_cycle_count (rsp_cycle_count),
      .o_reg_written (rsp_reg_written),
      .o_reg_index   (rsp_reg_index),
      .o_reg_value   (rsp_reg_value)
   );
endmodule
`default_nettype wire

/* src/ebx_divider.sv */
// ----------------------------------------------------------------------------
// ebx_divider: radix-2 restoring divider, 64-bit unsigned
// One quotient bit per cycle; quotient and remainder held until next start.
// ----------------------------------------------------------------------------
`default_nettype none
module ebx_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient,
   output logic [63:0]      remainder
);
   logic [63:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [64:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff, q_ff[63]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         d_in = divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            r_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[62:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = !busy_ff && !start;
   assign quotient = q_ff;
   assign remainder = r_ff;
endmodule
`default_nettype wire

/* src/ebx_datapath.sv */
// ----------------------------------------------------------------------------
// ebx_datapath: register file, decode, ALU, branch and status state
// Driven step by step by the controller through a command struct.
// ----------------------------------------------------------------------------
`default_nettype none
module ebx_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ebx_pkg::cmd_type  cmd,
   output ebx_pkg::sts_type       sts,
   input  wire logic              in_action,
   input  wire logic [63:0]       in_word,
   input  wire logic              csr_wr,
   input  wire logic              csr_idx,
   input  wire logic [16:0]       csr_val,
   output logic                   o_running,
   output logic                   o_halted,
   output logic                   o_div_zero,
   output logic                   o_illegal_op,
   output logic [31:0]            o_next_ip,
   output logic [63:0]            o_cycle_count,
   output logic                   o_reg_written,
   output logic [3:0]             o_reg_index,
   output logic [63:0]            o_reg_value
);
   import ebx_pkg::*;

   logic [63:0] regs_ff [NumRegs];
   logic [31:0] ip_ff;
   logic [63:0] cnt_ff;
   logic        halt_ff, dbz_ff, ill_ff;
   logic [16:0] tsize_ff;
   logic        cont_ff;
   logic        run_ff, wrote_ff;

   logic        act_ff;
   logic [63:0] word_ff;
   logic [63:0] a_ff, b_ff;

   // evaluated results
   logic [63:0] res_ff, res_in;
   logic        wr_ff, wr_in;
   logic        ok_ff, ok_in;       // executed (valid class)
   logic        setill_ff, setill_in, setdbz_ff, setdbz_in;
   logic        take_ff, take_in;
   logic        mul_ff, mul_in, div_ff, div_in, divop_ff, divop_in, w32_ff, w32_in;
   logic [63:0] mlo_ff, mhl_ff, mlh_ff;

   logic [31:0] imm;
   logic [15:0] off;
   logic [3:0]  src, dst, op;
   logic [2:0]  cls;
   logic        usereg;
   logic [63:0] imm64, bsel;
   logic [16:0] size;
   logic [16:0] rem;
   logic        can_run;

   logic        dv_start, dv_done;
   logic [63:0] dv_q, dv_r, dv_a, dv_b;

   assign imm    = word_ff[31:0];
   assign off    = word_ff[47:32];
   assign dst    = word_ff[51:48];
   assign src    = word_ff[55:52];
   assign cls    = word_ff[58:56];
   assign usereg = word_ff[59];
   assign op     = word_ff[63:60];
   assign imm64  = {{32{imm[31]}}, imm};
   assign size   = (tsize_ff > 17'(MaxTextBytes)) ? 17'(MaxTextBytes) : tsize_ff;
   assign rem    = size - ip_ff[16:0];
   assign can_run = !halt_ff && (ip_ff < {15'd0, size}) && (rem[2:0] == 3'd0);
   assign bsel   = usereg ? regs_ff[src] : imm64;

   function automatic logic [63:0] swap16(input logic [15:0] v);
      swap16 = {48'd0, v[7:0], v[15:8]};
   endfunction
   function automatic logic [31:0] swap32(input logic [31:0] v);
      swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   always_comb begin
      logic [63:0] a, b;
      logic [31:0] a32, b32;
      logic [5:0]  s64;
      logic [4:0]  s32;
      a = a_ff;
      b = b_ff;
      a32 = a[31:0];
      b32 = b[31:0];
      s64 = b[5:0];
      s32 = b[4:0];
      res_in = '0;
      wr_in = 1'b0;
      ok_in = can_run;
      setill_in = 1'b0;
      setdbz_in = 1'b0;
      take_in = 1'b0;
      mul_in = 1'b0;
      div_in = 1'b0;
      divop_in = 1'b0;
      w32_in = 1'b0;
      if (cls == CLASS_ALU64) begin
         wr_in = 1'b1;
         case (op)
            OP_ADD:  res_in = a + b;
            OP_SUB:  res_in = a - b;
            OP_MUL:  mul_in = 1'b1;
            OP_DIV, OP_MOD: begin
               if (b == '0) begin
                  wr_in = 1'b0;
                  setdbz_in = 1'b1;
               end else begin
                  div_in = 1'b1;
                  divop_in = (op == OP_MOD);
               end
            end
            OP_OR:   res_in = a | b;
            OP_AND:  res_in = a & b;
            OP_LSH:  res_in = a << s64;
            OP_RSH:  res_in = a >> s64;
            OP_NEG:  res_in = 64'd0 - a;
            OP_XOR:  res_in = a ^ b;
            OP_MOV:  res_in = b;
            OP_ARSH: res_in = $signed(a) >>> s64;
            default: begin
               wr_in = 1'b0;
               setill_in = 1'b1;
            end
         endcase
      end else if (cls == CLASS_ALU32) begin
         wr_in = 1'b1;
         w32_in = 1'b1;
         case (op)
            OP_ADD:  res_in = {32'd0, a32 + b32};
            OP_SUB:  res_in = {32'd0, a32 - b32};
            OP_MUL:  mul_in = 1'b1;
            OP_DIV, OP_MOD: begin
               if (b32 == '0) begin
                  wr_in = 1'b0;
                  setdbz_in = 1'b1;
               end else begin
                  div_in = 1'b1;
                  divop_in = (op == OP_MOD);
               end
            end
            OP_OR:   res_in = {32'd0, a32 | b32};
            OP_AND:  res_in = {32'd0, a32 & b32};
            OP_LSH:  res_in = {32'd0, a32 << s32};
            OP_RSH:  res_in = {32'd0, a32 >> s32};
            OP_NEG:  res_in = {32'd0, 32'd0 - a32};
            OP_XOR:  res_in = {32'd0, a32 ^ b32};
            OP_MOV:  res_in = {32'd0, b32};
            OP_ARSH: res_in = {32'd0, $signed(a32) >>> s32};
            OP_END: begin
               if (imm == 32'd16)
                  res_in = usereg ? swap16(a[15:0]) : {48'd0, a[15:0]};
               else if (imm == 32'd32)
                  res_in = usereg ? {32'd0, swap32(a32)} : {32'd0, a32};
               else if (imm == 32'd64)
                  res_in = usereg ? {swap32(a32), swap32(a[63:32])} : a;
               else begin
                  wr_in = 1'b0;
                  setill_in = 1'b1;
               end
            end
            default: begin
               wr_in = 1'b0;
               setill_in = 1'b1;
            end
         endcase
      end else if (cls == CLASS_JMP) begin
         case (op)
            BR_JA:   take_in = 1'b1;
            BR_JEQ:  take_in = (a == b);
            BR_JGT:  take_in = (a > b);
            BR_JGE:  take_in = (a >= b);
            BR_JSET: take_in = ((a & b) != '0);
            BR_JNE:  take_in = (a != b);
            BR_JLT:  take_in = (a < b);
            BR_JLE:  take_in = (a <= b);
            default: setill_in = 1'b1;
         endcase
      end else begin
         ok_in = 1'b0;
         setill_in = can_run;
      end
      if (!can_run) begin
         wr_in = 1'b0;
         setill_in = 1'b0;
         setdbz_in = 1'b0;
         mul_in = 1'b0;
         div_in = 1'b0;
      end
   end

   assign dv_start = cmd.div_start;
   assign dv_a = w32_ff ? {32'd0, a_ff[31:0]} : a_ff;
   assign dv_b = w32_ff ? {32'd0, b_ff[31:0]} : b_ff;

   ebx_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (dv_start),
      .dividend  (dv_a),
      .divisor   (dv_b),
      .done      (dv_done),
      .quotient  (dv_q),
      .remainder (dv_r)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= in_action;
         word_ff <= in_word;
      end
      a_ff <= regs_ff[word_ff[51:48]];
      b_ff <= bsel;
      if (cmd.exec) begin
         res_ff <= res_in;
         wr_ff <= wr_in;
         ok_ff <= ok_in;
         setill_ff <= setill_in;
         setdbz_ff <= setdbz_in;
         take_ff <= take_in;
         mul_ff <= mul_in;
         div_ff <= div_in;
         divop_ff <= divop_in;
         w32_ff <= w32_in;
         mlo_ff <= a_ff[31:0] * b_ff[31:0];
         mhl_ff <= {32'd0, a_ff[63:32] * b_ff[31:0]};
         mlh_ff <= {32'd0, a_ff[31:0] * b_ff[63:32]};
      end
      if (cmd.mul_step) begin
         if (w32_ff) res_ff <= {32'd0, mlo_ff[31:0]};
         else res_ff <= mlo_ff + {mhl_ff[31:0] + mlh_ff[31:0], 32'd0};
      end
      if (cmd.commit && div_ff) begin
         res_ff <= divop_ff ? dv_r : dv_q;
      end
   end

   // architectural state
   logic [31:0] ip_adv;
   always_comb begin
      ip_adv = ip_ff + (take_ff ? {{16{off[15]}}, off} : 32'd0) + 32'd8;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
         ip_ff <= '0;
         cnt_ff <= '0;
         halt_ff <= 1'b0;
         dbz_ff <= 1'b0;
         ill_ff <= 1'b0;
         tsize_ff <= '0;
         cont_ff <= 1'b0;
         run_ff <= 1'b0;
         wrote_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            if (csr_idx == CSR_TEXT_SIZE) tsize_ff <= csr_val;
            else cont_ff <= csr_val[0];
         end
         if (cmd.commit) begin
            run_ff <= 1'b0;
            wrote_ff <= 1'b0;
            if (act_ff) begin
               for (int i = 0; i < NumRegs; i++) regs_ff[i] <= '0;
               ip_ff <= '0;
               cnt_ff <= '0;
               halt_ff <= 1'b0;
               dbz_ff <= 1'b0;
               ill_ff <= 1'b0;
            end else begin
               if (setill_ff) begin
                  halt_ff <= 1'b1;
                  ill_ff <= 1'b1;
               end
               if (setdbz_ff) begin
                  halt_ff <= 1'b1;
                  dbz_ff <= 1'b1;
               end
               if (ok_ff) begin
                  if (wr_ff) regs_ff[dst] <= div_ff ? (divop_ff ? dv_r : dv_q) : res_ff;
                  wrote_ff <= wr_ff;
                  cnt_ff <= cnt_ff + 64'd1;
                  if (ip_adv == {15'd0, size}) begin
                     ip_ff <= cont_ff ? 32'd0 : ip_adv;
                     run_ff <= cont_ff;
                  end else begin
                     ip_ff <= ip_adv;
                     run_ff <= 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_running <= run_ff;
         o_halted <= halt_ff;
         o_div_zero <= dbz_ff;
         o_illegal_op <= ill_ff;
         o_next_ip <= ip_ff;
         o_cycle_count <= cnt_ff;
         o_reg_written <= wrote_ff;
         o_reg_index <= dst;
         o_reg_value <= regs_ff[dst];
      end
   end

   assign sts.is_clear  = act_ff;
   assign sts.needs_mul = mul_ff;
   assign sts.needs_div = div_ff;
   assign sts.div_done  = dv_done;
endmodule
`default_nettype wire

/* src/ebx_controller.sv */
// ----------------------------------------------------------------------------
// ebx_controller: sequencing state machine of the executor
// Walks each beat through read, execute, optional multiply/divide, commit, out.
// ----------------------------------------------------------------------------
`default_nettype none
module ebx_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire ebx_pkg::sts_type sts,
   output ebx_pkg::cmd_type      cmd,
   output logic                  csr_ready
);
   import ebx_pkg::*;

   state_type state_ff, state_in;
   logic      vld_ff, vld_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      vld_in = vld_ff && rsp_stall;
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_COMMIT;
            if (!sts.is_clear) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (sts.needs_mul) begin
               cmd.mul_step = 1'b1;
               state_in = ST_COMMIT;
            end else if (sts.needs_div) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else state_in = ST_COMMIT;
         end
         ST_DIV: if (sts.div_done) state_in = ST_COMMIT;
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!vld_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               vld_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = vld_ff;
   assign csr_ready = (state_ff == ST_IDLE);
endmodule
`default_nettype wire

/* src/ebx_checker.sv */
// ----------------------------------------------------------------------------
// ebx_checker: port-level checks of the executor
// Result beats versus request beats and flag behaviour.
// ----------------------------------------------------------------------------
`default_nettype none
module ebx_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_running,
   input wire logic        rsp_halted,
   input wire logic        rsp_div_zero,
   input wire logic        rsp_illegal_op,
   input wire logic [31:0] rsp_next_ip
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_ip))
      else $error("result beat changed under stall");
   a_req_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second beat taken while busy");
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_running) && $stable(rsp_halted))
      else $error("result flags changed under stall");
   a_flag_halt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_div_zero || rsp_illegal_op) |-> rsp_halted)
      else $error("error flag without halt");
endmodule

bind ebpf_instruction_executor ebx_checker u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_running    (rsp_running),
   .rsp_halted     (rsp_halted),
   .rsp_div_zero   (rsp_div_zero),
   .rsp_illegal_op (rsp_illegal_op),
   .rsp_next_ip    (rsp_next_ip)
);
`default_nettype wire

/* tb/sv/tb_ebpf_instruction_executor.sv */
// ----------------------------------------------------------------------------
// tb_ebpf_instruction_executor: self-checking bench of the instruction executor
// Drives clear and execute beats, predicts every result beat from an internal
// machine model and compares field by field, with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_ebpf_instruction_executor;
   timeunit 1ns;
   timeprecision 1ps;
   import ebx_pkg::*;

   typedef struct packed {
      logic        action;
      logic [63:0] word;
   } beat_type;

   typedef struct packed {
      logic        running;
      logic        halted;
      logic        div_zero;
      logic        illegal_op;
      logic [31:0] next_ip;
      logic [63:0] cycle_count;
      logic        reg_written;
      logic [3:0]  reg_index;
      logic [63:0] reg_value;
   } step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0;
   logic [63:0] req_instr_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_running, rsp_halted, rsp_div_zero, rsp_illegal_op, rsp_reg_written;
   logic [31:0] rsp_next_ip;
   logic [63:0] rsp_cycle_count, rsp_reg_value;
   logic [3:0] rsp_reg_index;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [16:0] csr_wdata = '0;

   ebpf_instruction_executor uut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // machine model
   logic [63:0] gpr [NumRegs];
   logic [31:0] pc;
   logic [63:0] n_exec;
   logic        f_halt, f_dbz, f_ill;
   logic [16:0] m_text_size;
   logic        m_continuous;

   beat_type pending_beats[$];
   step_type expected_steps[$];
   int errors = 0;
   int idle_pct = 26;
   int accepted = 0;

   function automatic logic [63:0] bswap(input logic [63:0] v, input int nbytes);
      logic [63:0] r;
      r = '0;
      for (int i = 0; i < nbytes; i++) r[8*i +: 8] = v[8*(nbytes-1-i) +: 8];
      return r;
   endfunction

   function automatic step_type execute_step(input beat_type b);
      step_type s;
      logic [31:0] imm, size, offs;
      logic [3:0] src, dst, op;
      logic [7:0] opc;
      logic [2:0] cls;
      logic use_reg, taken, wr, ok;
      logic [63:0] imm64, a, bb, res;
      logic [31:0] a32, b32, r32;
      logic [5:0] sh;
      imm = b.word[31:0];
      offs = {{16{b.word[47]}}, b.word[47:32]};
      dst = b.word[51:48];
      src = b.word[55:52];
      opc = b.word[63:56];
      op = opc[7:4];
      cls = opc[2:0];
      use_reg = opc[3];
      imm64 = {{32{imm[31]}}, imm};
      size = (m_text_size > MaxTextBytes) ? MaxTextBytes : 32'(m_text_size);
      s = '0;
      wr = 1'b0;
      res = '0;
      if (b.action) begin
         for (int i = 0; i < NumRegs; i++) gpr[i] = '0;
         pc = '0; n_exec = '0; f_halt = 0; f_dbz = 0; f_ill = 0;
      end else if (!f_halt && pc < size && ((size - pc) & 32'h7) == 0) begin
         a = gpr[dst];
         bb = use_reg ? gpr[src] : imm64;
         ok = 1'b1;
         if (cls == CLASS_ALU64) begin
            wr = 1'b1;
            sh = bb[5:0];
            case (op)
               OP_ADD: res = a + bb;
               OP_SUB: res = a - bb;
               OP_MUL: res = a * bb;
               OP_DIV, OP_MOD: begin
                  if (bb == 0) begin
                     f_halt = 1; f_dbz = 1; wr = 0;
                  end else res = (op == OP_DIV) ? a / bb : a % bb;
               end
               OP_OR:   res = a | bb;
               OP_AND:  res = a & bb;
               OP_LSH:  res = a << sh;
               OP_RSH:  res = a >> sh;
               OP_NEG:  res = -a;
               OP_XOR:  res = a ^ bb;
               OP_MOV:  res = bb;
               OP_ARSH: res = $signed(a) >>> sh;
               default: begin
                  f_halt = 1; f_ill = 1; wr = 0;
               end
            endcase
         end else if (cls == CLASS_ALU32) begin
            wr = 1'b1;
            a32 = a[31:0];
            b32 = bb[31:0];
            sh = {1'b0, bb[4:0]};
            r32 = '0;
            case (op)
               OP_ADD: r32 = a32 + b32;
               OP_SUB: r32 = a32 - b32;
               OP_MUL: r32 = a32 * b32;
               OP_DIV, OP_MOD: begin
                  if (b32 == 0) begin
                     f_halt = 1; f_dbz = 1; wr = 0;
                  end else r32 = (op == OP_DIV) ? a32 / b32 : a32 % b32;
               end
               OP_OR:   r32 = a32 | b32;
               OP_AND:  r32 = a32 & b32;
               OP_LSH:  r32 = a32 << sh;
               OP_RSH:  r32 = a32 >> sh;
               OP_NEG:  r32 = -a32;
               OP_XOR:  r32 = a32 ^ b32;
               OP_MOV:  r32 = b32;
               OP_ARSH: r32 = $signed(a32) >>> sh;
               OP_END: ;
               default: begin
                  f_halt = 1; f_ill = 1; wr = 0;
               end
            endcase
            res = {32'h0, r32};
            if (op == OP_END) begin
               if (imm == 16) res = use_reg ? bswap(a & 64'hffff, 2) : (a & 64'hffff);
               else if (imm == 32) res = use_reg ? bswap(a, 4) : {32'h0, a[31:0]};
               else if (imm == 64) res = use_reg ? bswap(a, 8) : a;
               else begin
                  f_halt = 1; f_ill = 1; wr = 0;
               end
            end
         end else if (cls == CLASS_JMP) begin
            taken = 1'b0;
            case (op)
               BR_JA:   taken = 1;
               BR_JEQ:  taken = (a == bb);
               BR_JGT:  taken = (a > bb);
               BR_JGE:  taken = (a >= bb);
               BR_JSET: taken = ((a & bb) != 0);
               BR_JNE:  taken = (a != bb);
               BR_JLT:  taken = (a < bb);
               BR_JLE:  taken = (a <= bb);
               default: begin
                  f_halt = 1; f_ill = 1;
               end
            endcase
            if (taken) pc = pc + offs;
         end else begin
            f_halt = 1; f_ill = 1; ok = 0;
         end
         if (ok) begin
            if (wr) gpr[dst] = res;
            pc = pc + 8;
            n_exec = n_exec + 1;
            s.running = 1'b1;
            if (pc == size) begin
               if (m_continuous) pc = '0;
               else s.running = 1'b0;
            end
         end
      end
      s.halted = f_halt;
      s.div_zero = f_dbz;
      s.illegal_op = f_ill;
      s.next_ip = pc;
      s.cycle_count = n_exec;
      s.reg_written = wr;
      s.reg_index = dst;
      s.reg_value = gpr[dst];
      return s;
   endfunction

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      errors++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            expected_steps.push_back(execute_step({req_action, req_instr_word}));
            accepted++;
         end
         if (pending_beats.size() > 0 && $urandom_range(99) >= idle_pct) begin
            beat_type b;
            b = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_action <= b.action;
            req_instr_word <= b.word;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_steps.size() == 0) begin
               report("unexpected beat", 0, 0);
            end else begin
               step_type e;
               e = expected_steps.pop_front();
               if (rsp_running !== e.running) report("running", rsp_running, e.running);
               if (rsp_halted !== e.halted) report("halted", rsp_halted, e.halted);
               if (rsp_div_zero !== e.div_zero) report("div_zero", rsp_div_zero, e.div_zero);
               if (rsp_illegal_op !== e.illegal_op)
                  report("illegal_op", rsp_illegal_op, e.illegal_op);
               if (rsp_next_ip !== e.next_ip) report("next_ip", rsp_next_ip, e.next_ip);
               if (rsp_cycle_count !== e.cycle_count)
                  report("cycle_count", rsp_cycle_count, e.cycle_count);
               if (rsp_reg_written !== e.reg_written)
                  report("reg_written", rsp_reg_written, e.reg_written);
               if (rsp_reg_index !== e.reg_index) report("reg_index", rsp_reg_index, e.reg_index);
               if (rsp_reg_value !== e.reg_value) report("reg_value", rsp_reg_value, e.reg_value);
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   function automatic logic [63:0] make_word(input logic [7:0] opc, input logic [3:0] src,
                                             input logic [3:0] dst, input logic [15:0] offs,
                                             input logic [31:0] imm);
      return {opc, src, dst, offs, imm};
   endfunction

   function automatic logic [63:0] rand_word();
      logic [3:0] op;
      logic [2:0] cls;
      logic [31:0] imm;
      logic [15:0] offs;
      int k;
      k = $urandom_range(99);
      case ($urandom_range(2))
         0: cls = CLASS_ALU64;
         1: cls = CLASS_ALU32;
         default: cls = CLASS_JMP;
      endcase
      if (k < 3) cls = 3'($urandom_range(7));
      op = 4'($urandom_range(15));
      if (k >= 10 && cls == CLASS_JMP && $urandom_range(3) != 0)
         op = ($urandom_range(1)) ? BR_JEQ : BR_JNE;
      if (k >= 10 && cls != CLASS_JMP && op > OP_END) op = 4'($urandom_range(13));
      // keep divides rare
      if ((op == OP_DIV || op == OP_MOD) && cls != CLASS_JMP && $urandom_range(3) != 0)
         op = OP_ADD;
      case ($urandom_range(3))
         0: imm = $urandom;
         1: imm = 32'($urandom_range(64));
         2: imm = ($urandom_range(1)) ? 32'hffffffff : 32'h80000000;
         default: imm = (op == OP_END) ? 32'(16 << $urandom_range(2)) : 32'($urandom_range(7));
      endcase
      offs = ($urandom_range(7) == 0) ? 16'($urandom) : 16'(8 * $urandom_range(6) - 16);
      return make_word({op, 1'($urandom_range(1)), cls}, 4'($urandom_range(15)),
                       4'($urandom_range(15)), offs, imm);
   endfunction

   task automatic wait_drained();
      while (pending_beats.size() > 0 || req_valid || expected_steps.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [16:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_TEXT_SIZE) m_text_size = data;
      else m_continuous = data[0];
      csr_valid <= 1'b0;
   endtask

   initial begin
      beat_type b;
      for (int i = 0; i < NumRegs; i++) gpr[i] = '0;
      pc = '0; n_exec = '0; f_halt = 0; f_dbz = 0; f_ill = 0;
      m_text_size = '0; m_continuous = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // text size zero: nothing runs
      pending_beats.push_back('{1'b0, 64'hffff_ffff_ffff_ffff});
      pending_beats.push_back('{1'b0, '0});
      wait_drained();

      write_csr(CSR_TEXT_SIZE, 17'd64);
      write_csr(CSR_CONTINUOUS, 1'b1);
      pending_beats.push_back('{1'b0, make_word({OP_MOV, 1'b0, CLASS_ALU64}, 0, 1, 0,
                                                32'h8000_0000)});
      pending_beats.push_back('{1'b0, make_word({OP_ARSH, 1'b0, CLASS_ALU64}, 0, 1, 0, 32'd68)});
      pending_beats.push_back('{1'b0, make_word({OP_NEG, 1'b0, CLASS_ALU64}, 0, 1, 0, 0)});
      pending_beats.push_back('{1'b0, make_word({OP_ARSH, 1'b1, CLASS_ALU32}, 1, 2, 0, 0)});
      pending_beats.push_back('{1'b0, make_word({OP_END, 1'b1, CLASS_ALU32}, 0, 1, 0, 32'd64)});
      pending_beats.push_back('{1'b0, make_word({OP_END, 1'b0, CLASS_ALU32}, 0, 1, 0, 32'd16)});
      pending_beats.push_back('{1'b0, make_word({BR_JGT, 1'b1, CLASS_JMP}, 2, 1, 16'h8, 0)});
      pending_beats.push_back('{1'b0, make_word({BR_JA, 1'b0, CLASS_JMP}, 0, 0, 16'hfff0, 0)});
      pending_beats.push_back('{1'b0, make_word({OP_MUL, 1'b0, CLASS_ALU64}, 0, 1, 0,
                                                32'hffffffff)});
      pending_beats.push_back('{1'b0, make_word({4'hf, 1'b0, CLASS_ALU64}, 0, 1, 0, 0)});
      pending_beats.push_back('{1'b0, '0});
      pending_beats.push_back('{1'b1, 64'hffff_ffff_ffff_ffff});
      pending_beats.push_back('{1'b0, make_word({OP_DIV, 1'b0, CLASS_ALU64}, 0, 3, 0, 0)});
      pending_beats.push_back('{1'b1, '0});
      pending_beats.push_back('{1'b0, make_word({OP_MOD, 1'b1, CLASS_ALU32}, 4, 3, 0, 0)});
      pending_beats.push_back('{1'b1, '0});
      pending_beats.push_back('{1'b0, make_word({OP_END, 1'b0, CLASS_ALU32}, 0, 3, 0, 32'd8)});
      pending_beats.push_back('{1'b1, '0});
      pending_beats.push_back('{1'b0, make_word({BR_JSET, 1'b0, CLASS_JMP}, 0, 0, 0, 0) |
                                      64'h0600_0000_0000_0000});
      pending_beats.push_back('{1'b1, '0});
      wait_drained();

      // odd size without wrap, then end-of-text with wrap, then the extremes
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: write_csr(CSR_TEXT_SIZE, 17'd20);
            1: write_csr(CSR_TEXT_SIZE, 17'd48);
            2: write_csr(CSR_TEXT_SIZE, 17'h1ffff);
            3: write_csr(CSR_TEXT_SIZE, 17'd65536);
            4: write_csr(CSR_TEXT_SIZE, 17'd8);
            default: write_csr(CSR_TEXT_SIZE, 17'd128);
         endcase
         write_csr(CSR_CONTINUOUS, (ph % 2 == 0) ? 1'b0 : 1'b1);
         if (ph == 5) write_csr(CSR_CONTINUOUS, 1'b1);
         idle_pct = (ph == 2) ? 0 : 26;
         for (int n = 0; n < 325; n++) begin
            b.action = ($urandom_range(24) == 0);
            b.word = rand_word();
            if ($urandom_range(40) == 0) b.word = {$urandom, $urandom};
            pending_beats.push_back(b);
         end
         wait_drained();
      end

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("TB_ERROR");
      $finish;
   end
endmodule
`default_nettype wire
